// File: rtl/gmp_pkg.sv
// shared types and constants of the gossip message parser
package gmp_pkg;

   // key length in bytes, and field position counter width
   localparam int KEY_BYTES = 32;
   localparam int FPOS_W    = 6;

   // parse phases
   typedef enum logic [2:0] {
      PH_VER,
      PH_SUBCNT,
      PH_SUBKEY,
      PH_FRCNT,
      PH_FRKEY,
      PH_TIME,
      PH_LIVE
   } phase_type;

   // byte kind codes
   localparam logic [2:0] KIND_VERSION   = 3'd0;
   localparam logic [2:0] KIND_SUB_COUNT = 3'd1;
   localparam logic [2:0] KIND_SUB_KEY   = 3'd2;
   localparam logic [2:0] KIND_FR_COUNT  = 3'd3;
   localparam logic [2:0] KIND_FR_KEY    = 3'd4;
   localparam logic [2:0] KIND_TIME      = 3'd5;
   localparam logic [2:0] KIND_LIVE      = 3'd6;
   localparam logic [2:0] KIND_IGNORED   = 3'd7;

   // completion status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_BAD_VER   = 2'd1;
   localparam logic [1:0] STATUS_OVER      = 2'd2;
   localparam logic [1:0] STATUS_TRUNCATED = 2'd3;

   // register indexes
   localparam logic [1:0] CSR_EXP_VERSION = 2'd0;
   localparam logic [1:0] CSR_MAX_SUBS    = 2'd1;
   localparam logic [1:0] CSR_MAX_FRESH   = 2'd2;

   // register reset values
   localparam logic [7:0]  EXP_VERSION_RST = 8'd1;
   localparam logic [15:0] MAX_COUNT_RST   = 16'd1024;

   // parser state
   typedef struct packed {
      phase_type         phase;
      logic [FPOS_W-1:0] field_pos;
      logic [15:0]       entry_cnt;
      logic [15:0]       count_val;
      logic [31:0]       time_acc;
      logic              finished;
   } state_type;

   localparam state_type STATE_RESET = '{PH_VER, 6'd0, 16'd0, 16'd0, 32'd0, 1'b0};

   // configuration registers
   typedef struct packed {
      logic [7:0]  exp_version;
      logic [15:0] max_subs;
      logic [15:0] max_recs;
   } cfg_type;

   // one result beat
   typedef struct packed {
      logic [2:0]  byte_kind;
      logic [15:0] entry_index;
      logic [4:0]  byte_offset;
      logic [7:0]  byte_value;
      logic [31:0] timestamp;
      logic        timestamp_valid;
      logic        live_flag;
      logic        done_res;
      logic [1:0]  status;
   } result_type;

endpackage

// File: rtl/gmp_step.sv
// next-state and result logic for one payload byte
module gmp_step
   import gmp_pkg::*;
(
   input  state_type  cur_state,
   input  cfg_type    cfg,
   input  logic [7:0] pay_byte,
   input  logic       eop,
   output state_type  nxt_state,
   output result_type res
);

   logic              done;
   logic [1:0]        stat;
   logic [15:0]       new_count;
   logic [15:0]       limit;
   logic [15:0]       entry_inc;
   logic [FPOS_W-1:0] fpos_inc;
   logic [1:0]        toff;
   logic [31:0]       acc_new;

   always_comb begin
      nxt_state      = cur_state;
      res            = '0;
      res.byte_kind  = KIND_IGNORED;
      res.byte_value = pay_byte;
      done           = 1'b0;
      stat           = STATUS_OK;
      new_count      = {pay_byte, cur_state.count_val[7:0]};
      limit          = (cur_state.phase == PH_SUBCNT) ? cfg.max_subs : cfg.max_recs;
      entry_inc      = cur_state.entry_cnt + 16'd1;
      fpos_inc       = cur_state.field_pos + FPOS_W'(1);
      toff           = cur_state.field_pos[1:0];
      acc_new        = cur_state.time_acc | ({24'd0, pay_byte} << {toff, 3'b000});
      if (toff == 2'd0) begin
         acc_new = {24'd0, pay_byte};
      end

      if (cur_state.finished) begin
         // trailing bytes after the parse ended
         if (eop) begin
            nxt_state = STATE_RESET;
         end
      end else begin
         case (cur_state.phase)
            // two-byte little-endian counts
            PH_SUBCNT, PH_FRCNT: begin
               res.byte_kind   = (cur_state.phase == PH_SUBCNT) ? KIND_SUB_COUNT
                                                                : KIND_FR_COUNT;
               res.byte_offset = {4'd0, cur_state.field_pos[0]};
               if (cur_state.field_pos == '0) begin
                  nxt_state.count_val = {8'd0, pay_byte};
                  nxt_state.field_pos = FPOS_W'(1);
               end else begin
                  nxt_state.count_val = new_count;
                  nxt_state.field_pos = '0;
                  nxt_state.entry_cnt = '0;
                  if (new_count > limit) begin
                     done = 1'b1;
                     stat = STATUS_OVER;
                  end else if (new_count == 16'd0) begin
                     if (cur_state.phase == PH_SUBCNT) begin
                        nxt_state.phase = PH_FRCNT;
                     end else begin
                        done = 1'b1;
                     end
                  end else begin
                     nxt_state.phase = (cur_state.phase == PH_SUBCNT) ? PH_SUBKEY
                                                                      : PH_FRKEY;
                  end
               end
            end
            // key bytes
            PH_SUBKEY, PH_FRKEY: begin
               res.byte_kind   = (cur_state.phase == PH_SUBKEY) ? KIND_SUB_KEY
                                                                : KIND_FR_KEY;
               res.entry_index = cur_state.entry_cnt;
               res.byte_offset = cur_state.field_pos[4:0];
               if (fpos_inc >= FPOS_W'(KEY_BYTES)) begin
                  nxt_state.field_pos = '0;
                  if (cur_state.phase == PH_FRKEY) begin
                     nxt_state.phase = PH_TIME;
                  end else begin
                     nxt_state.entry_cnt = entry_inc;
                     if (entry_inc >= cur_state.count_val) begin
                        nxt_state.entry_cnt = '0;
                        nxt_state.phase     = PH_FRCNT;
                     end
                  end
               end else begin
                  nxt_state.field_pos = fpos_inc;
               end
            end
            // timestamp bytes, assembled little-endian
            PH_TIME: begin
               res.byte_kind      = KIND_TIME;
               res.entry_index    = cur_state.entry_cnt;
               res.byte_offset    = {3'd0, toff};
               res.timestamp      = acc_new;
               nxt_state.time_acc = acc_new;
               if (toff == 2'd3) begin
                  res.timestamp_valid = 1'b1;
                  nxt_state.field_pos = '0;
                  nxt_state.phase     = PH_LIVE;
               end else begin
                  nxt_state.field_pos = {{(FPOS_W-2){1'b0}}, toff} + FPOS_W'(1);
               end
            end
            // live byte closes a fresh record
            PH_LIVE: begin
               res.byte_kind       = KIND_LIVE;
               res.entry_index     = cur_state.entry_cnt;
               res.timestamp       = cur_state.time_acc;
               res.live_flag       = |pay_byte;
               nxt_state.entry_cnt = entry_inc;
               nxt_state.field_pos = '0;
               if (entry_inc >= cur_state.count_val) begin
                  done = 1'b1;
               end else begin
                  nxt_state.phase = PH_FRKEY;
               end
            end
            // version byte
            default: begin
               res.byte_kind = KIND_VERSION;
               if (pay_byte != cfg.exp_version) begin
                  done = 1'b1;
                  stat = STATUS_BAD_VER;
               end else begin
                  nxt_state.phase     = PH_SUBCNT;
                  nxt_state.field_pos = '0;
               end
            end
         endcase

         // payload ended early
         if (!done && eop) begin
            done = 1'b1;
            stat = STATUS_TRUNCATED;
         end
         if (done) begin
            if (eop) begin
               nxt_state = STATE_RESET;
            end else begin
               nxt_state.finished = 1'b1;
            end
         end
         res.done_res = done;
         res.status   = stat;
      end
   end

endmodule

// File: rtl/gossip_message_parser_unit.sv
// gossip message parser: one payload byte in, one tagged result beat out
// path: an accepted req beat passes the input register, then the result register, to its rsp beat
// throughput: 1 byte per cycle while rsp_tready holds; the parse state updates as a byte moves to the result register
// reset: synchronous, active high; clears the parse state and valid flags and loads the configuration registers
// (expected version 1, both count limits 1024)
module gossip_message_parser_unit
   import gmp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] payload_byte
   input  logic        req_tlast,   // end_of_payload
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [15:0] entry_index, [20:16] byte_offset, [28:21] byte_value,
   // [60:29] timestamp, [61] timestamp_valid, [62] live_flag, [64:63] status,
   // [71:65] zero
   output logic [71:0] rsp_tdata,
   output logic [2:0]  rsp_tuser,   // [2:0] byte_kind
   output logic        rsp_tlast,   // done_res
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   cfg_type    cfg_ff;
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   state_type  state_ff;
   state_type  state_in;
   logic       out_valid_ff;
   result_type out_res_ff;
   result_type res_in;
   logic       advance;

   // configuration writes are always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.exp_version <= EXP_VERSION_RST;
         cfg_ff.max_subs    <= MAX_COUNT_RST;
         cfg_ff.max_recs    <= MAX_COUNT_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_EXP_VERSION: cfg_ff.exp_version <= csr_data[7:0];
            CSR_MAX_SUBS:    cfg_ff.max_subs    <= csr_data;
            CSR_MAX_FRESH:   cfg_ff.max_recs    <= csr_data;
            default: ;
         endcase
      end
   end

   // pipeline moves when the result register is free or being drained
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata[7:0];
         in_last_ff <= req_tlast;
      end
   end

   // parse logic
   gmp_step u_step (
      .cur_state (state_ff),
      .cfg       (cfg_ff),
      .pay_byte  (in_byte_ff),
      .eop       (in_last_ff),
      .nxt_state (state_in),
      .res       (res_in)
   );

   // parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_res_ff <= res_in;
      end
   end

   // result beat packing
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_res_ff.byte_kind;
   assign rsp_tlast  = out_res_ff.done_res;
   assign rsp_tdata  = {7'd0,
                        out_res_ff.status,
                        out_res_ff.live_flag,
                        out_res_ff.timestamp_valid,
                        out_res_ff.timestamp,
                        out_res_ff.byte_value,
                        out_res_ff.byte_offset,
                        out_res_ff.entry_index};

`ifndef SYNTHESIS
   // an ending byte with end of payload leaves the parser at a fresh start
   a_restart_on_eop: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) && $past(advance && res_in.done_res && in_last_ff) |->
         (state_ff.phase == PH_VER) && (state_ff.entry_cnt == 16'd0) && !state_ff.finished)
      else $error("parser did not restart after ending on the last byte");

   // once finished, every byte is tagged as ignored
   a_finished_ignored: assert property (@(posedge clock) disable iff (reset)
      advance && state_ff.finished |-> (res_in.byte_kind == KIND_IGNORED) && !res_in.done_res)
      else $error("byte after the parse ended was not ignored");

   // an ignored beat never ends a parse
   a_ignored_not_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_IGNORED) |-> !rsp_tlast && (rsp_tdata[15:0] == 16'd0))
      else $error("ignored beat carries done or an entry index");

   // a complete timestamp only appears on a timestamp byte
   a_ts_valid_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[61] |-> (rsp_tuser == KIND_TIME) && (rsp_tdata[20:16] == 5'd3))
      else $error("timestamp valid outside the last timestamp byte");
`endif

endmodule
